/* design/mi3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

	localparam int ELEM_W = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int THR_W = 48;
	localparam logic [THR_W-1:0] THR_RESET = 48'd281475;
	localparam int LANES = 9;
	localparam int PROD_W = 64;
	localparam int ADJ_W = 65;
	localparam int PART_W = 65;
	localparam int DET_W = 99;
	localparam int DMAG_W = 98;
	// one quotient bit per cell; bit 32 only flags overflow
	localparam int QBITS = 33;

	// adjugate entry i = m[PL_A]*m[PL_B] - m[PR_A]*m[PR_B]
	localparam int PL_A [LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int PL_B [LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int PR_A [LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int PR_B [LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
	// first-row cofactors for the determinant
	localparam int COF_IDX [3] = '{0, 3, 6};

	typedef logic [LANES-1:0][ELEM_W-1:0] mat_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] a00;
		logic signed [ELEM_W-1:0] a01;
		logic signed [ELEM_W-1:0] a02;
		logic signed [ELEM_W-1:0] a10;
		logic signed [ELEM_W-1:0] a11;
		logic signed [ELEM_W-1:0] a12;
		logic signed [ELEM_W-1:0] a20;
		logic signed [ELEM_W-1:0] a21;
		logic signed [ELEM_W-1:0] a22;
	} in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] r00;
		logic signed [ELEM_W-1:0] r01;
		logic signed [ELEM_W-1:0] r02;
		logic signed [ELEM_W-1:0] r10;
		logic signed [ELEM_W-1:0] r11;
		logic signed [ELEM_W-1:0] r12;
		logic signed [ELEM_W-1:0] r20;
		logic signed [ELEM_W-1:0] r21;
		logic signed [ELEM_W-1:0] r22;
		logic signed [ELEM_W-1:0] determinant_value;
		logic singular;
		logic saturated;
	} out_t;

	typedef struct packed {
		logic [LANES-1:0][DMAG_W-1:0] rem;
		logic [LANES-1:0][QBITS-1:0] qn;
		logic [LANES-1:0] qneg;
		logic [LANES-1:0] ovf;
		logic [DMAG_W-1:0] dmag;
		in_t mat;
		logic [ELEM_W-1:0] det_out;
		logic sing;
		logic det_clip;
	} cell_t;

	function automatic mat_t to_mat(input in_t a);
		mat_t m;
		m[0] = a.a00; m[1] = a.a01; m[2] = a.a02;
		m[3] = a.a10; m[4] = a.a11; m[5] = a.a12;
		m[6] = a.a20; m[7] = a.a21; m[8] = a.a22;
		return m;
	endfunction

	// clip a sign-magnitude quotient to 32-bit two's complement
	function automatic logic [ELEM_W:0] sat_q(input logic [QBITS-1:0] q, input logic neg,
			input logic ovf);
		logic [QBITS-1:0] lim;
		logic clip;
		logic [ELEM_W-1:0] v;
		lim = neg ? 33'h080000000 : 33'h07FFFFFFF;
		clip = ovf || (q > lim);
		if (clip) begin
			v = neg ? 32'h80000000 : 32'h7FFFFFFF;
		end else begin
			v = neg ? (32'd0 - q[ELEM_W-1:0]) : q[ELEM_W-1:0];
		end
		return {clip, v};
	endfunction

endpackage
`default_nettype wire

/* design/mi3_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi3_front #(
	parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                en,
	input  wire                                vld_in,
	input  mi3_pkg::in_t                       din,
	input  wire  [mi3_pkg::THR_W-1:0]          thr,
	output logic                               vld_out,
	output mi3_pkg::cell_t                     dout
);
	localparam int SH = 2 * FRACTION_BITS;
	localparam int NUMW = mi3_pkg::PROD_W + SH;
	localparam int HIW = NUMW - mi3_pkg::QBITS;
	localparam int NL = mi3_pkg::LANES;
	localparam int DMW = mi3_pkg::DMAG_W;

	mi3_pkg::mat_t m_in;
	mi3_pkg::mat_t m_s2;
	logic [6:0] vld_q;

	logic signed [mi3_pkg::PROD_W-1:0] pl_s1 [NL];
	logic signed [mi3_pkg::PROD_W-1:0] pr_s1 [NL];
	mi3_pkg::in_t mat_s1, mat_s2, mat_s3, mat_s4, mat_s5, mat_s6;
	logic signed [mi3_pkg::ADJ_W-1:0] adj_s2 [NL];
	logic signed [mi3_pkg::PART_W-1:0] plo_s3 [3];
	logic signed [mi3_pkg::PART_W-1:0] phi_s3 [3];
	logic [mi3_pkg::PROD_W-1:0] adjm_s3 [NL];
	logic [NL-1:0] adjn_s3;
	logic signed [mi3_pkg::DET_W-1:0] term_s4 [3];
	logic [mi3_pkg::PROD_W-1:0] adjm_s4 [NL];
	logic [NL-1:0] adjn_s4;
	logic signed [mi3_pkg::DET_W-1:0] det_s5;
	logic [mi3_pkg::PROD_W-1:0] adjm_s5 [NL];
	logic [NL-1:0] adjn_s5;
	logic [DMW-1:0] dmag_s6;
	logic dneg_s6;
	logic [mi3_pkg::PROD_W-1:0] adjm_s6 [NL];
	logic [NL-1:0] adjn_s6;
	mi3_pkg::cell_t cell_s7;

	logic [DMW-1:0] dsh;
	logic det_clip;
	logic [DMW-1:0] det_lim;
	logic [mi3_pkg::ELEM_W-1:0] det_v;

	assign m_in = mi3_pkg::to_mat(din);
	assign m_s2 = mi3_pkg::to_mat(mat_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[5:0], vld_in};
		end
	end

	// determinant output saturation
	always_comb begin
		dsh = dmag_s6 >> SH;
		det_lim = dneg_s6 ? DMW'(33'h080000000) : DMW'(33'h07FFFFFFF);
		det_clip = dsh > det_lim;
		if (det_clip) begin
			det_v = dneg_s6 ? 32'h80000000 : 32'h7FFFFFFF;
		end else begin
			det_v = dneg_s6 ? (32'd0 - dsh[31:0]) : dsh[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1 <= din;
			mat_s2 <= mat_s1;
			mat_s3 <= mat_s2;
			mat_s4 <= mat_s3;
			mat_s5 <= mat_s4;
			mat_s6 <= mat_s5;
			for (int i = 0; i < NL; i++) begin
				pl_s1[i] <= {{32{m_in[mi3_pkg::PL_A[i]][31]}}, m_in[mi3_pkg::PL_A[i]]}
					* {{32{m_in[mi3_pkg::PL_B[i]][31]}}, m_in[mi3_pkg::PL_B[i]]};
				pr_s1[i] <= {{32{m_in[mi3_pkg::PR_A[i]][31]}}, m_in[mi3_pkg::PR_A[i]]}
					* {{32{m_in[mi3_pkg::PR_B[i]][31]}}, m_in[mi3_pkg::PR_B[i]]};
				adj_s2[i] <= {pl_s1[i][63], pl_s1[i]} - {pr_s1[i][63], pr_s1[i]};
				adjn_s3[i] <= adj_s2[i][64];
				adjm_s3[i] <= adj_s2[i][64] ? 64'(-adj_s2[i]) : adj_s2[i][63:0];
				adjm_s4[i] <= adjm_s3[i];
				adjm_s5[i] <= adjm_s4[i];
				adjm_s6[i] <= adjm_s5[i];
			end
			adjn_s4 <= adjn_s3;
			adjn_s5 <= adjn_s4;
			adjn_s6 <= adjn_s5;
			// split each 65-bit cofactor into two narrow products
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= {{33{m_s2[k][31]}}, m_s2[k]}
					* {33'd0, adj_s2[mi3_pkg::COF_IDX[k]][31:0]};
				phi_s3[k] <= {{33{m_s2[k][31]}}, m_s2[k]}
					* {{32{adj_s2[mi3_pkg::COF_IDX[k]][64]}},
					   adj_s2[mi3_pkg::COF_IDX[k]][64:32]};
				term_s4[k] <= ({{34{phi_s3[k][64]}}, phi_s3[k]} <<< 32)
					+ {{34{plo_s3[k][64]}}, plo_s3[k]};
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			dneg_s6 <= det_s5[98];
			dmag_s6 <= det_s5[98] ? DMW'(-det_s5) : det_s5[DMW-1:0];
			// set up the divider lanes
			for (int i = 0; i < NL; i++) begin
				logic [NUMW-1:0] num;
				logic [HIW-1:0] hi;
				logic ov;
				num = NUMW'(adjm_s6[i]) << SH;
				hi = num[NUMW-1:mi3_pkg::QBITS];
				ov = DMW'(hi) >= dmag_s6;
				cell_s7.ovf[i] <= ov;
				cell_s7.rem[i] <= ov ? '0 : DMW'(hi);
				cell_s7.qn[i] <= num[mi3_pkg::QBITS-1:0];
				cell_s7.qneg[i] <= adjn_s6[i] ^ dneg_s6;
			end
			cell_s7.dmag <= dmag_s6;
			cell_s7.mat <= mat_s6;
			cell_s7.det_out <= det_v;
			cell_s7.det_clip <= det_clip;
			cell_s7.sing <= (dmag_s6 == '0) || (dmag_s6 < DMW'(thr));
		end
	end

	assign vld_out = vld_q[6];
	assign dout = cell_s7;

endmodule
`default_nettype wire

/* design/mi3_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi3_cell (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  wire             vld_in,
	input  mi3_pkg::cell_t  din,
	output logic            vld_out,
	output mi3_pkg::cell_t  dout
);
	localparam int DMW = mi3_pkg::DMAG_W;
	localparam int QB = mi3_pkg::QBITS;

	logic vld_q;
	mi3_pkg::cell_t nxt, cell_q;

	// one restoring-division step per lane: bring down the next numerator bit
	always_comb begin
		nxt = din;
		for (int i = 0; i < mi3_pkg::LANES; i++) begin
			logic [DMW:0] t;
			logic [DMW:0] d;
			logic ge;
			t = {din.rem[i], din.qn[i][QB-1]};
			d = {1'b0, din.dmag};
			ge = t >= d;
			nxt.rem[i] = ge ? DMW'(t - d) : t[DMW-1:0];
			nxt.qn[i] = {din.qn[i][QB-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign dout = cell_q;

endmodule
`default_nettype wire

/* design/mi3_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi3_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             vld_in,
	input  mi3_pkg::cell_t  din,
	output logic            en,
	output logic            out_valid,
	input  wire             out_stall,
	output mi3_pkg::out_t   out_data
);
	localparam int NL = mi3_pkg::LANES;

	mi3_pkg::out_t res, out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic take, load;
	logic [NL-1:0] clip;
	logic [NL-1:0][mi3_pkg::ELEM_W-1:0] qv;
	mi3_pkg::mat_t m;

	always_comb begin
		m = mi3_pkg::to_mat(din.mat);
		for (int i = 0; i < NL; i++) begin
			{clip[i], qv[i]} = mi3_pkg::sat_q(din.qn[i], din.qneg[i], din.ovf[i]);
			if (din.sing) begin
				qv[i] = m[i];
			end
		end
		res.r00 = qv[0]; res.r01 = qv[1]; res.r02 = qv[2];
		res.r10 = qv[3]; res.r11 = qv[4]; res.r12 = qv[5];
		res.r20 = qv[6]; res.r21 = qv[7]; res.r22 = qv[8];
		res.determinant_value = din.det_out;
		res.singular = din.sing;
		res.saturated = din.det_clip | (~din.sing & (|clip));
	end

	// pipeline freezes only while the skid word is held
	assign en = ~skid_vld_q;
	assign take = vld_in & en;
	assign load = ~out_vld_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= skid_vld_q | take;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (take) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

/* design/matrix3x3_inverse.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted input word reaches its result word through 7 product/determinant
// stages, 33 divider cells and 1 output register. One matrix per cycle is taken
// while in_stall is low; nine divider lanes per cell, one quotient bit each.
// A stalled output holds one more word in a skid register, then in_stall rises.
// arst_n clears all valid bits and loads the singular threshold with 281475.
module matrix3x3_inverse #(
	parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  mi3_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  wire                          out_stall,
	output mi3_pkg::out_t                out_data,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [mi3_pkg::THR_W-1:0]    cfg_data
);
	localparam int QB = mi3_pkg::QBITS;

	logic en;
	logic [mi3_pkg::THR_W-1:0] thr_q;
	logic vld_c [QB+1];
	mi3_pkg::cell_t cell_c [QB+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mi3_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	assign in_stall = ~en;

	mi3_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(in_valid & ~in_stall), .din(in_data), .thr(thr_q),
		.vld_out(vld_c[0]), .dout(cell_c[0])
	);

	for (genvar g = 0; g < QB; g++) begin : g_cell
		mi3_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_c[g]), .din(cell_c[g]),
			.vld_out(vld_c[g+1]), .dout(cell_c[g+1])
		);
	end

	mi3_back u_back (
		.clk(clk), .arst_n(arst_n),
		.vld_in(vld_c[QB]), .din(cell_c[QB]), .en(en),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
`default_nettype wire

/* design/mi3_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi3_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            in_stall,
	input wire            out_valid,
	input wire            out_stall,
	input mi3_pkg::out_t  out_data,
	input wire            cfg_ready
);
	// held word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("output word dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data)) else $error("output word changed");
	// skid fills only behind a stalled output word
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without output stall");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid) else $error("input stalled with empty output");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("config port not ready");
endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data), .cfg_ready(cfg_ready)
);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam int N_RANDOM = 1880;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD = 400;
	localparam logic [mi3_pkg::THR_W-1:0] THR_MAX = '1;

	typedef struct {
		mi3_pkg::in_t mat;
		bit typed;
		mi3_pkg::out_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mi3_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mi3_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mi3_pkg::THR_W-1:0] cfg_data = '0;

	logic [mi3_pkg::THR_W-1:0] thr_shadow = mi3_pkg::THR_RESET;
	mi3_pkg::out_t expected_q[$];
	bit typed_q[$];
	mi3_pkg::out_t typed_res_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit quiet = 1'b0;

	always #6 clk = ~clk;

	matrix3x3_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function automatic logic [31:0] clip32(input logic [127:0] mag, input logic neg,
			inout logic clip);
		logic [127:0] lim;
		lim = neg ? 128'h80000000 : 128'h7FFFFFFF;
		if (mag > lim) begin
			mag = lim;
			clip = 1'b1;
		end
		return neg ? 32'(-mag) : mag[31:0];
	endfunction

	function automatic mi3_pkg::out_t invert(input mi3_pkg::in_t a,
			input logic [mi3_pkg::THR_W-1:0] thr);
		logic [8:0][31:0] e;
		logic signed [127:0] m[9];
		logic signed [127:0] det;
		logic signed [127:0] adj[9];
		logic [127:0] dmag;
		logic [127:0] q;
		logic [8:0][31:0] rv;
		logic [31:0] dv;
		logic dneg, sing, clip;
		e = a;
		clip = 1'b0;
		for (int i = 0; i < 9; i++) m[i] = signed'(e[8-i]);
		det = m[0]*m[4]*m[8] + m[2]*m[3]*m[7] + m[1]*m[5]*m[6]
			- m[0]*m[7]*m[5] - m[1]*m[3]*m[8] - m[2]*m[4]*m[6];
		dneg = det[127];
		dmag = dneg ? -det : det;
		dv = clip32(dmag >> 32, dneg, clip);
		sing = (dmag == 0) || (dmag < {80'd0, thr});
		adj[0] = m[4]*m[8] - m[5]*m[7];
		adj[1] = m[2]*m[7] - m[1]*m[8];
		adj[2] = m[1]*m[5] - m[2]*m[4];
		adj[3] = m[5]*m[6] - m[3]*m[8];
		adj[4] = m[0]*m[8] - m[2]*m[6];
		adj[5] = m[2]*m[3] - m[0]*m[5];
		adj[6] = m[3]*m[7] - m[4]*m[6];
		adj[7] = m[1]*m[6] - m[0]*m[7];
		adj[8] = m[0]*m[4] - m[1]*m[3];
		for (int i = 0; i < 9; i++) begin
			if (sing) begin
				rv[8-i] = e[8-i];
			end else begin
				q = ((adj[i][127] ? -adj[i] : adj[i]) << 32) / dmag;
				rv[8-i] = clip32(q, adj[i][127] != dneg, clip);
			end
		end
		return mi3_pkg::out_t'({rv, dv, sing, clip});
	endfunction

	function automatic logic [31:0] rand_elem(input int kind);
		case (kind)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 262143)) - 131072);
			2: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
			default: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
		endcase
	endfunction

	function automatic mi3_pkg::in_t rand_matrix();
		logic [8:0][31:0] e;
		int pick, kind;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 2);
		for (int i = 0; i < 9; i++) e[i] = rand_elem($urandom_range(0, 9) == 0 ? 3 : kind);
		if (pick < 30) begin
			// strengthen the diagonal so most of these are well conditioned
			e[8] = e[8] + 32'h00040000;
			e[4] = e[4] - 32'h00050000;
			e[0] = e[0] + 32'h00030000;
		end else if (pick < 40) begin
			// copy a row to make an exactly singular matrix
			e[2:0] = e[8:6];
		end else if (pick < 48) begin
			// tiny elements give determinants near the threshold
			for (int i = 0; i < 9; i++) e[i] = 32'($signed($urandom_range(0, 255)) - 128);
		end
		return mi3_pkg::in_t'(e);
	endfunction

	function automatic int rand_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// bookkeeping at each edge
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			if (typed_q.pop_front()) expected_q.push_back(typed_res_q.pop_front());
			else begin
				void'(typed_res_q.pop_front());
				expected_q.push_back(invert(in_data, thr_shadow));
			end
		end
		if (cfg_valid && cfg_ready) thr_shadow <= cfg_data;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", out_data);
			end else begin
				mi3_pkg::out_t exp_w;
				exp_w = expected_q.pop_front();
				if (out_data !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch\n  exp %p\n  got %p", exp_w, out_data);
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side stalls
	initial begin
		int r, n;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				n = r < 90 ? $urandom_range(1, 4) : $urandom_range(10, 40);
				out_stall <= !quiet && r >= 55;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_matrix(input mi3_pkg::in_t w, input bit typed,
			input mi3_pkg::out_t res);
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_q.push_back(typed);
		typed_res_q.push_back(res);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_threshold(input logic [mi3_pkg::THR_W-1:0] thr);
		in_valid <= 1'b0;
		// let the last accepted word reach the queue first
		@(posedge clk);
		wait (expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= thr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic mi3_pkg::in_t diag(input logic [31:0] d);
		logic [8:0][31:0] e;
		e = '0;
		e[8] = d;
		e[4] = d;
		e[0] = d;
		return mi3_pkg::in_t'(e);
	endfunction

	initial begin
		row_t rows[$];
		logic [mi3_pkg::THR_W-1:0] thr_plan[4];
		row_t rw;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity: its own inverse, determinant one
		rw.mat = diag(32'h00010000);
		rw.typed = 1;
		rw.res = mi3_pkg::out_t'({diag(32'h00010000), 32'h00010000, 1'b0, 1'b0});
		rows.push_back(rw);
		// zero matrix: zero determinant passes through
		rw.mat = '0;
		rw.res = '0;
		rw.res.singular = 1'b1;
		rows.push_back(rw);
		// one lsb on the diagonal: determinant far below threshold
		rw.mat = diag(32'd1);
		rw.res = mi3_pkg::out_t'({diag(32'd1), 32'd0, 1'b1, 1'b0});
		rows.push_back(rw);
		rw.typed = 0;
		rw.res = '0;
		rw.mat = diag(32'h80000000); rows.push_back(rw);
		rw.mat = diag(32'h7FFFFFFF); rows.push_back(rw);
		rw.mat = '1; rows.push_back(rw);
		rw.mat = {9{32'h80000000}}; rows.push_back(rw);
		rw.mat = diag(32'h00000100); rows.push_back(rw);
		rw.mat = diag(32'hFFFF0000); rows.push_back(rw);
		rw.mat = diag(32'h00008000); rows.push_back(rw);
		rw.mat = mi3_pkg::in_t'({32'h00020000, 32'h00010000, 32'd0, 32'h00010000,
			32'h00030000, 32'hFFFF0000, 32'd0, 32'h00010000, 32'h00040000});
		rows.push_back(rw);
		rw.mat = mi3_pkg::in_t'({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF, 32'h12345678});
		rows.push_back(rw);
		foreach (rows[i]) send_matrix(rows[i].mat, rows[i].typed, rows[i].res);

		thr_plan[0] = mi3_pkg::THR_RESET;
		thr_plan[1] = '0;
		thr_plan[2] = THR_MAX;
		thr_plan[3] = {$urandom(), 16'($urandom())} >> $urandom_range(0, 40);
		for (int p = 0; p < 4; p++) begin
			write_threshold(thr_plan[p]);
			quiet = (p == 1);
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				if (p == 0 && i == 100) hold_req = 1'b1;
				send_matrix(rand_matrix(), 1'b0, '0);
			end
			quiet = 1'b0;
		end
		// edge of the threshold: exactly equal is not singular
		write_threshold(48'd16777216);
		send_matrix(diag(32'h00000100), 1'b0, '0);
		send_matrix(diag(32'h000000FF), 1'b0, '0);
		in_valid <= 1'b0;

		@(posedge clk);
		wait (expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
design/mi3_pkg.sv
design/mi3_front.sv
design/mi3_cell.sv
design/mi3_back.sv
design/matrix3x3_inverse.sv
design/mi3_checker.sv
tb/sv/tb.sv
